// File: design/u8s_pkg.sv
// ----------------------------------------------------------------------------
// u8s_pkg: shared types and constants of the UTF-8 sanitizer
// Byte classes, the replacement character and the job descriptor that the
// front end hands to the back end through the job queue.
// ----------------------------------------------------------------------------
package u8s_pkg;

  localparam logic [7:0] REPL_CHAR = 8'h3F;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  // Most result bytes one input byte can cause
  localparam int unsigned JOB_SLOTS = 4;
  localparam int unsigned SLOT_W    = $clog2(JOB_SLOTS);
  localparam int unsigned CNT_W     = $clog2(JOB_SLOTS + 1);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Result bytes of one input byte, slot 0 goes out first
  typedef struct packed {
    logic [JOB_SLOTS-1:0][7:0] bytes;
    logic [JOB_SLOTS-1:0]      repl;
    logic [CNT_W-1:0]          cnt;   // 1 .. JOB_SLOTS
    logic                      last;  // byte closed the text
  } job_t;

  // Continuations a lead byte asks for, zero if it is no lead byte
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if ((b & LEAD2_MASK) == LEAD2_CODE) n = 2'd1;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) n = 2'd2;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) n = 2'd3;
    return n;
  endfunction

endpackage

// File: design/utf8_sanitizer_core.sv
// ----------------------------------------------------------------------------
// utf8_sanitizer_core: UTF-8 validation with '?' replacement
//
//   channel | dir | tdata          | tuser                        | tlast
//   in_     | in  | [7:0] byte     | -                            | final byte
//   out_    | out | [7:0] out_byte | [0] was_replaced [1] run_last | text end
//
// One byte is accepted per cycle; each input byte yields one result byte
// overall, so the stream runs at one byte per cycle in steady state. A byte
// that completes a held sequence yields up to four results, which the back
// end sends one per cycle while the four-entry job queue absorbs new input.
// Synchronous active-low reset empties the held sequence and the queue.
// Input stalls only when the job queue is full; output stalls hold the
// output register.
// ----------------------------------------------------------------------------
module utf8_sanitizer_core
  import u8s_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] was_replaced, [1] run_last
  output logic       out_tlast
);

  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  logic repl;
  logic run_last;

  u8s_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .q_full   (q_full),
    .q_push   (push),
    .q_job    (push_job)
  );

  u8s_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  u8s_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_tdata),
    .out_repl     (repl),
    .out_run_last (run_last),
    .out_text_end (out_tlast)
  );

  assign out_tuser = {run_last, repl};

endmodule

// File: design/u8s_front.sv
// ----------------------------------------------------------------------------
// u8s_front: byte classifier and sequence holder
// Tracks the partly received multi-byte sequence and turns every accepted
// byte that causes result bytes into a job that lists those bytes.
// ----------------------------------------------------------------------------
module u8s_front
  import u8s_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       in_ready,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [2:0][7:0] held_r, held_nxt;
  logic [1:0]      held_cnt_r, held_cnt_nxt;
  logic [1:0]      need_r, need_nxt;

  logic            accept;
  logic            is_cont;
  logic [1:0]      fresh_need;
  logic            fresh_buf;
  logic [7:0]      fresh_byte;
  logic            fresh_repl;

  logic            pass;
  logic [1:0]      pre_cnt;
  logic            tail_en;
  logic [7:0]      tail_byte;
  logic            tail_repl;
  logic [3:0][7:0] held_ext;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_cont  = (in_byte & CONT_MASK) == CONT_CODE;
  assign held_ext = {8'h00, held_r};

  always_comb begin
    fresh_need = lead_need(in_byte);
    fresh_buf  = in_byte[7] && (fresh_need != 2'd0) && !in_last;
    fresh_byte = in_byte[7] ? REPL_CHAR : in_byte;
    fresh_repl = in_byte[7];

    // Default: flush whatever is held as '?', then treat the byte afresh
    pass      = 1'b0;
    pre_cnt   = held_cnt_r;
    tail_en   = !fresh_buf;
    tail_byte = fresh_byte;
    tail_repl = fresh_repl;
    held_nxt     = '0;
    held_cnt_nxt = 2'd0;
    need_nxt     = 2'd0;
    if (fresh_buf) begin
      held_nxt[0]  = in_byte;
      held_cnt_nxt = 2'd1;
      need_nxt     = fresh_need;
    end

    if ((held_cnt_r != 2'd0) && is_cont) begin
      if (need_r <= 2'd1) begin
        // sequence complete: pass it through unchanged
        pass         = 1'b1;
        tail_en      = 1'b1;
        tail_byte    = in_byte;
        tail_repl    = 1'b0;
        held_nxt     = '0;
        held_cnt_nxt = 2'd0;
        need_nxt     = 2'd0;
      end else if (in_last) begin
        // text ends mid-sequence: held bytes and this one become '?'
        pre_cnt      = held_cnt_r + 2'd1;
        tail_en      = 1'b0;
        held_nxt     = '0;
        held_cnt_nxt = 2'd0;
        need_nxt     = 2'd0;
      end else begin
        pre_cnt      = 2'd0;
        tail_en      = 1'b0;
        held_nxt     = held_r;
        if (held_cnt_r == 2'd1) held_nxt[1] = in_byte;
        else                    held_nxt[2] = in_byte;
        held_cnt_nxt = held_cnt_r + 2'd1;
        need_nxt     = need_r - 2'd1;
      end
    end

    for (int i = 0; i < JOB_SLOTS; i++) begin
      if (CNT_W'(i) < CNT_W'(pre_cnt)) begin
        q_job.bytes[i] = pass ? held_ext[i] : REPL_CHAR;
        q_job.repl[i]  = !pass;
      end else begin
        q_job.bytes[i] = tail_byte;
        q_job.repl[i]  = tail_repl;
      end
    end
    q_job.cnt  = CNT_W'(pre_cnt) + CNT_W'(tail_en);
    q_job.last = in_last;
  end

  assign q_push = accept && (q_job.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      held_cnt_r <= 2'd0;
      need_r     <= 2'd0;
    end else if (accept) begin
      held_r     <= held_nxt;
      held_cnt_r <= held_cnt_nxt;
      need_r     <= need_nxt;
    end
  end

endmodule

// File: design/u8s_queue.sv
// ----------------------------------------------------------------------------
// u8s_queue: job queue
// Short first-in first-out store of jobs between front end and back end.
// ----------------------------------------------------------------------------
module u8s_queue
  import u8s_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t            mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r;
  logic [QAW-1:0]  rd_ptr_r;
  logic [QCW-1:0]  count_r;
  logic            do_push;
  logic            do_pop;

  assign empty   = count_r == '0;
  assign full    = count_r == QCW'(QDEPTH);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCW'(1);
        2'b01:   count_r <= count_r - QCW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: design/u8s_back.sv
// ----------------------------------------------------------------------------
// u8s_back: result sequencer
// Walks the head job slot by slot and drives one result byte per cycle
// into the output register while the output does not stall.
// ----------------------------------------------------------------------------
module u8s_back
  import u8s_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_repl,
  output logic       out_run_last,
  output logic       out_text_end
);

  logic [SLOT_W-1:0] slot_r;
  logic              valid_r;
  logic [7:0]        byte_r;
  logic              repl_r;
  logic              run_last_r;
  logic              text_end_r;
  logic              load;
  logic              slot_end;

  assign load     = !valid_r || out_ready;
  assign slot_end = (CNT_W'(slot_r) + CNT_W'(1)) == head.cnt;
  assign q_pop    = load && !q_empty && slot_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= '0;
    end else if (load) begin
      valid_r <= !q_empty;
      if (!q_empty) slot_r <= slot_end ? '0 : slot_r + SLOT_W'(1);
    end
  end

  // Payload: hold while the output stalls
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      byte_r     <= head.bytes[slot_r];
      repl_r     <= head.repl[slot_r];
      run_last_r <= slot_end;
      text_end_r <= slot_end && head.last;
    end
  end

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign out_repl     = repl_r;
  assign out_run_last = run_last_r;
  assign out_text_end = text_end_r;

endmodule

// File: bench/utf8_sanitizer_checker.sv
// ----------------------------------------------------------------------------
// utf8_sanitizer_checker: result checker for the UTF-8 sanitizer
// Watches both stream channels, works out the cleaned bytes of every input
// transaction from its own copy of the held sequence, and compares each
// output transaction with the oldest cleaned byte still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_sanitizer_checker
  import u8s_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_byte
  input  logic [1:0] out_tuser,  // [0] was_replaced, [1] run_last
  input  logic       out_tlast,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0] ch;
    logic       repl;
    logic       run_end;
    logic       text_end;
  } clean_byte_t;

  clean_byte_t clean_q[$];   // cleaned bytes awaited on the output
  clean_byte_t step_res[$];  // cleaned bytes of the current input byte

  logic [23:0] held_seq;     // lead in 7:0, continuations above
  logic [1:0]  held_cnt;
  logic [1:0]  need_cnt;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    held_seq    = '0;
    held_cnt    = '0;
    need_cnt    = '0;
  end

  function automatic void put(input logic [7:0] c, input logic rp);
    clean_byte_t r;
    r = '{ch: c, repl: rp, run_end: 1'b0, text_end: 1'b0};
    step_res = {step_res, r};
  endfunction

  // Turn every held byte into a replacement and empty the hold
  function automatic void flush_held();
    int k;
    for (k = 0; k < int'(held_cnt); k++) put(REPL_CHAR, 1'b1);
    held_seq = '0;
    held_cnt = '0;
    need_cnt = '0;
  endfunction

  function automatic void start_fresh(input logic [7:0] b, input logic fin);
    logic [1:0] want;
    want = 2'd0;
    if (b[7] == 1'b0) begin
      put(b, 1'b0);
      return;
    end
    if ((b & LEAD2_MASK) == LEAD2_CODE) want = 2'd1;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) want = 2'd2;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) want = 2'd3;
    if (want == 2'd0 || fin) begin
      put(REPL_CHAR, 1'b1);
      return;
    end
    held_seq = {16'h0000, b};
    held_cnt = 2'd1;
    need_cnt = want;
  endfunction

  function automatic void sanitize_byte(input logic [7:0] b, input logic fin);
    clean_byte_t r;
    int k;
    step_res.delete();
    if (held_cnt != 2'd0) begin
      if ((b & CONT_MASK) == CONT_CODE) begin
        if (need_cnt <= 2'd1) begin
          for (k = 0; k < int'(held_cnt); k++) put(held_seq[8*k +: 8], 1'b0);
          put(b, 1'b0);
          held_seq = '0;
          held_cnt = '0;
          need_cnt = '0;
        end else begin
          held_seq[8*held_cnt +: 8] = b;
          held_cnt = held_cnt + 2'd1;
          need_cnt = need_cnt - 2'd1;
          if (fin) flush_held();
        end
      end else begin
        flush_held();
        start_fresh(b, fin);
      end
    end else begin
      start_fresh(b, fin);
    end
    // Mark the closing byte of this transaction, then queue them all
    if (step_res.size() > 0) begin
      r = step_res[step_res.size()-1];
      r.run_end  = 1'b1;
      r.text_end = fin;
      step_res[step_res.size()-1] = r;
    end
    clean_q = {clean_q, step_res};
  endfunction

  always @(posedge clk) begin
    clean_byte_t want, got;
    if (!rst_n) begin
      clean_q.delete();
      held_seq = '0;
      held_cnt = '0;
      need_cnt = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{ch: out_tdata, repl: out_tuser[0], run_end: out_tuser[1],
                text_end: out_tlast};
        if (clean_q.size() == 0) begin
          $display("%0t: unexpected result byte %02h repl %b run_last %b text_end %b",
                   $time, got.ch, got.repl, got.run_end, got.text_end);
          mismatches <= mismatches + 1;
        end else begin
          want = clean_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected byte %02h repl %b run_last %b text_end %b, %s",
                     $time, want.ch, want.repl, want.run_end, want.text_end,
                     $sformatf("got byte %02h repl %b run_last %b text_end %b",
                               got.ch, got.repl, got.run_end, got.text_end));
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_tvalid && in_tready) sanitize_byte(in_tdata, in_tlast);
    end
    outstanding <= clean_q.size();
  end

endmodule

// File: bench/utf8_sanitizer_core_test.sv
// ----------------------------------------------------------------------------
// utf8_sanitizer_core_test: testbench of the UTF-8 sanitizer
// Drives directed byte texts covering each sequence length, broken and
// unfinished sequences and stray bytes, then random texts built mostly of
// well-formed sequences, with random idling on both channels. The checker
// beside the block predicts and compares every result byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_sanitizer_core_test;

  localparam int RANDOM_ITEMS = 195;
  localparam int CALM_ITEMS   = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic [1:0] out_tuser;  // [0] was_replaced, [1] run_last
  logic       out_tlast;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int stall_left  = 0;
  int sent        = 0;
  bit idle_on     = 1'b1;
  bit calm        = 1'b0;

  utf8_sanitizer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  utf8_sanitizer_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver stalls in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Hold off the sender until every awaited result byte has come
  task automatic drain_wait();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] lead_byte(input int n);
    case (n)
      1:       return {3'b110, 5'($urandom)};
      2:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Any byte that cannot continue a sequence
  function automatic logic [7:0] breaker_byte();
    case ($urandom_range(0, 2))
      0:       return {1'b0, 7'($urandom)};
      1:       return lead_byte($urandom_range(1, 3));
      default: return {5'b11111, 3'($urandom)};
    endcase
  endfunction

  function automatic logic rand_fin();
    return ($urandom_range(0, 15) == 0);
  endfunction

  initial begin
    int kind;
    int n;
    int k;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // ASCII extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // complete two, three and four byte sequences
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // stray continuations and invalid leads
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b0);
    // lead broken by ASCII, then a held pair broken by a new lead
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    // text ends inside a sequence, on a lead, then on plain ASCII
    send_byte(8'hF4, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hE2, 1'b1);
    send_byte(8'h41, 1'b1);
    drain_wait();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (sent >= 80 && sent < 86) drain_wait();
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        repeat ($urandom_range(1, 4)) send_byte({1'b0, 7'($urandom)}, rand_fin());
      end else if (kind < 65) begin
        n = $urandom_range(1, 3);
        send_byte(lead_byte(n), rand_fin());
        for (k = 0; k < n; k++) send_byte(cont_byte(), rand_fin());
      end else if (kind < 80) begin
        n = $urandom_range(1, 3);
        send_byte(lead_byte(n), rand_fin());
        repeat ($urandom_range(0, n - 1)) send_byte(cont_byte(), rand_fin());
        send_byte(breaker_byte(), rand_fin());
      end else if (kind < 88) begin
        send_byte(cont_byte(), rand_fin());
      end else if (kind < 94) begin
        send_byte({5'b11111, 3'($urandom)}, rand_fin());
      end else begin
        send_byte(lead_byte($urandom_range(1, 3)), 1'b1);
      end
    end
    // close the text so nothing stays held
    send_byte({1'b0, 7'($urandom)}, 1'b1);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
design/u8s_pkg.sv
design/u8s_front.sv
design/u8s_queue.sv
design/u8s_back.sv
design/utf8_sanitizer_core.sv
bench/utf8_sanitizer_checker.sv
bench/utf8_sanitizer_core_test.sv
